// ===== rtl/core/int128_divider_top_assert.svh =====
// Assertion macros for the 128-bit divider.
`ifndef INT128_DIVIDER_TOP_ASSERT_SVH
`define INT128_DIVIDER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that the consequent holds in the same cycle as the antecedent.
`define I128D_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("divider check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define I128D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("divider check failed");

`else

`define I128D_ASSERT_SAME(label, ante, cons)
`define I128D_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/i128d_pkg.sv =====
`timescale 1ns / 1ps

package i128d_pkg;

   localparam int HalfWidth  = 64;
   localparam int WordWidth  = 2 * HalfWidth;
   localparam int CountWidth = $clog2(WordWidth);

   localparam logic [HalfWidth-1:0] SignMask = 64'h8000_0000_0000_0000;

   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [WordWidth-1:0] word_type;
   typedef logic [WordWidth:0]   wide_type;

endpackage

// ===== rtl/core/int128_divider_top.sv =====
`timescale 1ns / 1ps
// 128-bit signed / unsigned integer divider.
//
// Request channel: drive start with req_type and the dividend and divisor
// halves; the request is taken at a rising edge where start is high and busy
// is low. busy stays high while a division runs.
// Response channel: rsp_valid is high for exactly one cycle with the quotient,
// the remainder and rsp_divide_by_zero. There is no backpressure; the
// receiver must take the response in that cycle.
// Sequence: from the accepting edge a normal division passes through the
// dividend negation step, the divisor negation step, 128 shift-subtract
// steps and the quotient and remainder sign fix steps, then raises rsp_valid.
// busy falls with rsp_valid, so a new request is taken only after the last
// division is done. A zero divisor skips the loop: the response comes in the
// cycle after accept. All steps share one 129-bit subtractor.
// Signed division truncates toward zero; the remainder follows the dividend
// sign. Reset returns the sequencer to idle and drops any pending response.
module int128_divider_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_type,
   input  i128d_pkg::half_type  req_dividend_low,
   input  i128d_pkg::half_type  req_dividend_high,
   input  i128d_pkg::half_type  req_divisor_low,
   input  i128d_pkg::half_type  req_divisor_high,
   output logic                 rsp_valid,
   output i128d_pkg::half_type  rsp_quotient_low,
   output i128d_pkg::half_type  rsp_quotient_high,
   output i128d_pkg::half_type  rsp_remainder_low,
   output i128d_pkg::half_type  rsp_remainder_high,
   output logic                 rsp_divide_by_zero
);
   import i128d_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_N,
      ST_NEG_D,
      ST_DIVIDE,
      ST_FIX_Q,
      ST_FIX_R
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   word_type              quo_ff, quo_in;
   word_type              rem_ff, rem_in;
   word_type              div_ff, div_in;
   logic                  nneg_ff, nneg_in;
   logic                  dneg_ff, dneg_in;
   logic                  dbz_ff, dbz_in;
   logic                  valid_ff, valid_in;

   wide_type              sub_a;
   word_type              sub_b;
   word_type              sub_diff;
   logic                  sub_borrow;
   logic                  accept;
   logic                  divisor_zero;

   i128d_sub u_sub (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .diff       (sub_diff),
      .borrow     (sub_borrow)
   );

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign divisor_zero = (req_divisor_low == '0) && (req_divisor_high == '0);

   // Route the shared subtractor for the current step.
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         ST_NEG_N: begin
            sub_b = quo_ff;
         end
         ST_NEG_D: begin
            sub_b = div_ff;
         end
         ST_DIVIDE: begin
            sub_a = {rem_ff, quo_ff[WordWidth-1]};
            sub_b = div_ff;
         end
         ST_FIX_Q: begin
            sub_b = quo_ff;
         end
         ST_FIX_R: begin
            sub_b = rem_ff;
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      nneg_in  = nneg_ff;
      dneg_in  = dneg_ff;
      dbz_in   = dbz_ff;
      valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (divisor_zero) begin
                  quo_in   = '1;
                  rem_in   = {req_dividend_high, req_dividend_low};
                  dbz_in   = 1'b1;
                  valid_in = 1'b1;
               end else begin
                  quo_in   = {req_dividend_high, req_dividend_low};
                  div_in   = {req_divisor_high, req_divisor_low};
                  rem_in   = '0;
                  dbz_in   = 1'b0;
                  nneg_in  = req_type && ((req_dividend_high & SignMask) != '0);
                  dneg_in  = req_type && ((req_divisor_high & SignMask) != '0);
                  state_in = ST_NEG_N;
               end
            end
         end
         ST_NEG_N: begin
            if (nneg_ff) quo_in = sub_diff;
            state_in = ST_NEG_D;
         end
         ST_NEG_D: begin
            if (dneg_ff) div_in = sub_diff;
            count_in = '1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Shift the next dividend bit into the remainder; keep the
            // difference when it did not borrow.
            quo_in = {quo_ff[WordWidth-2:0], !sub_borrow};
            rem_in = sub_borrow ? {rem_ff[WordWidth-2:0], quo_ff[WordWidth-1]} : sub_diff;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) state_in = ST_FIX_Q;
         end
         ST_FIX_Q: begin
            if (nneg_ff != dneg_ff) quo_in = sub_diff;
            state_in = ST_FIX_R;
         end
         ST_FIX_R: begin
            if (nneg_ff) rem_in = sub_diff;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      nneg_ff  <= nneg_in;
      dneg_ff  <= dneg_in;
      dbz_ff   <= dbz_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_quotient_low   = quo_ff[HalfWidth-1:0];
   assign rsp_quotient_high  = quo_ff[WordWidth-1:HalfWidth];
   assign rsp_remainder_low  = rem_ff[HalfWidth-1:0];
   assign rsp_remainder_high = rem_ff[WordWidth-1:HalfWidth];
   assign rsp_divide_by_zero = dbz_ff;

`include "int128_divider_top_assert.svh"

   `I128D_ASSERT_SAME(a_rsp_idle, valid_ff, state_ff == ST_IDLE)
   `I128D_ASSERT_NEXT(a_zero_fast, accept && divisor_zero, valid_ff && dbz_ff)
   `I128D_ASSERT_NEXT(a_loop_exit, state_ff == ST_DIVIDE && count_ff == '0, state_ff == ST_FIX_Q)
   `I128D_ASSERT_NEXT(a_rsp_pulse, valid_ff && !(accept && divisor_zero), !valid_ff)
   `I128D_ASSERT_NEXT(a_start_loop, accept && !divisor_zero, state_ff == ST_NEG_N && !dbz_ff)

endmodule

// ===== rtl/core/i128d_sub.sv =====
`timescale 1ns / 1ps

module i128d_sub (
   input  i128d_pkg::wide_type minuend,
   input  i128d_pkg::word_type subtrahend,
   output i128d_pkg::word_type diff,
   output logic                borrow
);
   import i128d_pkg::*;

   logic [WordWidth+1:0] full_diff;

   // One extra bit on top catches the borrow of the widened subtract.
   assign full_diff = {1'b0, minuend} - {2'b00, subtrahend};
   assign diff      = full_diff[WordWidth-1:0];
   assign borrow    = full_diff[WordWidth+1];

endmodule

// ===== dv/tb_int128_divider_top.sv =====
`timescale 1ns / 1ps

module tb_int128_divider_top;
   import i128d_pkg::*;

   localparam int RandomRequests = 650;
   localparam int DrainCycles    = 140;
   localparam int StallLimit     = 5000;

   typedef struct {
      word_type quotient;
      word_type remainder;
      logic     div_by_zero;
   } division_type;

   class division_scoreboard;
      division_type due_divisions[$];
      int           mismatches = 0;

      function automatic division_type compute_division(logic is_signed, word_type num,
                                                        word_type den);
         division_type res;
         logic         num_neg;
         logic         den_neg;
         word_type     num_mag;
         word_type     den_mag;
         word_type     q_mag;
         word_type     r_mag;
         res.div_by_zero = (den == '0);
         if (res.div_by_zero) begin
            res.quotient  = '1;
            res.remainder = num;
         end else begin
            num_neg = is_signed && num[WordWidth-1];
            den_neg = is_signed && den[WordWidth-1];
            num_mag = num_neg ? -num : num;
            den_mag = den_neg ? -den : den;
            q_mag   = num_mag / den_mag;
            r_mag   = num_mag % den_mag;
            // truncate toward zero; remainder follows the dividend sign
            res.quotient  = (num_neg != den_neg) ? -q_mag : q_mag;
            res.remainder = num_neg ? -r_mag : r_mag;
         end
         return res;
      endfunction

      task report_mismatch(string what, word_type got, word_type want);
         $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
         mismatches++;
      endtask

      function void note_request(logic is_signed, word_type num, word_type den);
         due_divisions.push_back(compute_division(is_signed, num, den));
      endfunction

      task check_response(half_type q_lo, half_type q_hi, half_type r_lo, half_type r_hi,
                          logic dz);
         division_type want;
         if (due_divisions.size() == 0) begin
            report_mismatch("response with no request pending", {q_hi, q_lo}, '0);
         end else begin
            want = due_divisions.pop_front();
            if (q_lo !== want.quotient[HalfWidth-1:0])
               report_mismatch("quotient_low", word_type'(q_lo),
                               word_type'(want.quotient[HalfWidth-1:0]));
            if (q_hi !== want.quotient[WordWidth-1:HalfWidth])
               report_mismatch("quotient_high", word_type'(q_hi),
                               word_type'(want.quotient[WordWidth-1:HalfWidth]));
            if (r_lo !== want.remainder[HalfWidth-1:0])
               report_mismatch("remainder_low", word_type'(r_lo),
                               word_type'(want.remainder[HalfWidth-1:0]));
            if (r_hi !== want.remainder[WordWidth-1:HalfWidth])
               report_mismatch("remainder_high", word_type'(r_hi),
                               word_type'(want.remainder[WordWidth-1:HalfWidth]));
            if (dz !== want.div_by_zero)
               report_mismatch("divide_by_zero", word_type'(dz),
                               word_type'(want.div_by_zero));
         end
      endtask
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   logic     req_type = 1'b0;
   half_type req_dividend_low  = '0;
   half_type req_dividend_high = '0;
   half_type req_divisor_low   = '0;
   half_type req_divisor_high  = '0;
   logic     rsp_valid;
   half_type rsp_quotient_low;
   half_type rsp_quotient_high;
   half_type rsp_remainder_low;
   half_type rsp_remainder_high;
   logic     rsp_divide_by_zero;

   division_scoreboard divisions = new();
   int                 stall_cycles = 0;

   int128_divider_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_dividend_low   (req_dividend_low),
      .req_dividend_high  (req_dividend_high),
      .req_divisor_low    (req_divisor_low),
      .req_divisor_high   (req_divisor_high),
      .rsp_valid          (rsp_valid),
      .rsp_quotient_low   (rsp_quotient_low),
      .rsp_quotient_high  (rsp_quotient_high),
      .rsp_remainder_low  (rsp_remainder_low),
      .rsp_remainder_high (rsp_remainder_high),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            divisions.note_request(req_type, {req_dividend_high, req_dividend_low},
                                   {req_divisor_high, req_divisor_low});
         if (rsp_valid)
            divisions.check_response(rsp_quotient_low, rsp_quotient_high,
                                     rsp_remainder_low, rsp_remainder_high,
                                     rsp_divide_by_zero);
         if ((start && !busy) || rsp_valid)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // hold the request until an edge with busy low takes it
   task automatic send_request(logic is_signed, word_type num, word_type den);
      req_type          <= is_signed;
      req_dividend_low  <= num[HalfWidth-1:0];
      req_dividend_high <= num[WordWidth-1:HalfWidth];
      req_divisor_low   <= den[HalfWidth-1:0];
      req_divisor_high  <= den[WordWidth-1:HalfWidth];
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // poll between edges so the monitor has noted the last request
   task automatic wait_for_drain();
      start <= 1'b0;
      @(negedge clock);
      while (divisions.due_divisions.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic word_type pick_operand();
      word_type v;
      v = {$urandom(), $urandom(), $urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = {SignMask, {HalfWidth{1'b0}}};
         3: v = {~SignMask, {HalfWidth{1'b1}}};
         4: v = v >> $urandom_range(64, 127);
         5: v = -(v >> $urandom_range(64, 127));
         6: v = word_type'(1) << $urandom_range(0, 127);
         7: v = v >> $urandom_range(0, 127);
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      word_type most_neg;
      word_type most_pos;
      word_type minus_one;
      int       sent;
      int       burst;
      most_neg  = {SignMask, {HalfWidth{1'b0}}};
      most_pos  = ~most_neg;
      minus_one = '1;
      sent      = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, both modes, zero divisor, most negative over minus one, sign rules
      send_request(1'b0, '1, word_type'(1));
      send_request(1'b0, '1, '1);
      send_request(1'b0, '0, '1);
      send_request(1'b0, word_type'(12345), '0);
      send_request(1'b1, most_neg, '0);
      send_request(1'b0, '0, '0);
      send_request(1'b1, most_neg, minus_one);
      send_request(1'b1, most_neg, word_type'(1));
      send_request(1'b1, -word_type'(7), word_type'(2));
      send_request(1'b1, word_type'(7), -word_type'(2));
      send_request(1'b1, -word_type'(7), -word_type'(2));
      send_request(1'b1, word_type'(7), word_type'(2));
      send_request(1'b0, most_neg, word_type'(3));
      send_request(1'b1, most_pos, most_neg);
      send_request(1'b1, most_neg, most_neg);
      send_request(1'b1, '0, minus_one);
      send_request(1'b0, word_type'(5), '1);
      send_request(1'b0, '1, {64'h1, 64'h0});
      send_request(1'b1, minus_one, most_pos);
      send_request(1'b0, {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210},
                   {64'h0, 64'hffff_ffff_ffff_fffd});
      wait_for_drain();

      while (sent < RandomRequests) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            send_request(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
            sent++;
         end
         case ($urandom_range(0, 5))
            0, 1: ;
            2: idle_gap($urandom_range(1, 5));
            3, 4: idle_gap($urandom_range(1, 200));
            default: wait_for_drain();
         endcase
      end

      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (divisions.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
